### sv/cle_pkg.sv
// Shared types and constants for the canonical line editor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cle_pkg;

    localparam int LINE_BYTES_DEF = 1024;
    localparam int READ_BURST_DEF = 64;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO     = 2'd0,
        KIND_DATA     = 2'd1,
        KIND_NOTREADY = 2'd2,
        KIND_REFUSED  = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;
        logic echo_sp;
        logic echo_bs2;
        logic rd_fetch;
        logic rd_emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic bs_go;
        logic rd_go;
        logic rd_last;
        logic line_ready;
        logic fill_zero;
    } t_status;

endpackage

### sv/cle_datapath.sv
// Datapath of the canonical line editor: line store, counters and result register.
// Depends on cle_pkg; driven by cle_ctrl through t_cmd.
`timescale 1ns / 1ps

module cle_datapath #(
    parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEF,
    parameter int READ_BURST = cle_pkg::READ_BURST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cle_pkg::t_cmd     i_cmd,
    output cle_pkg::t_status  o_status,
    input  logic              i_operation,
    input  logic [7:0]        i_char_byte,
    input  logic [6:0]        i_read_count,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_data,
    output logic              o_last
);

    localparam int FILL_W = $clog2(LINE_BYTES);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_BYTES - 1);
    localparam logic [6:0] BURST = 7'(READ_BURST);

    logic [7:0]        r_mem [LINE_BYTES];
    logic [7:0]        r_mem_q;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_rd_idx;
    logic              r_ready;
    logic [6:0]        r_want;
    logic [6:0]        r_cnt;
    logic              r_out_valid;
    cle_pkg::t_kind    r_kind;
    logic [7:0]        r_data;
    logic              r_last;

    logic              is_read;
    logic              is_eol;
    logic              is_bs;
    logic              printable;
    logic              has_room;
    logic              fill_zero;
    logic              idx_end;
    logic              rd_last;
    logic              mem_we;
    logic [7:0]        mem_wd;
    logic              ld;
    cle_pkg::t_kind    ld_kind;
    logic [7:0]        ld_data;
    logic              ld_last;
    logic              out_free;

    assign is_read   = (i_operation == cle_pkg::OP_READ);
    assign is_eol    = (i_char_byte == cle_pkg::CH_CR) || (i_char_byte == cle_pkg::CH_LF);
    assign is_bs     = (i_char_byte == cle_pkg::CH_BS) || (i_char_byte == cle_pkg::CH_DEL);
    assign printable = (i_char_byte >= cle_pkg::CH_SPACE) && (i_char_byte < cle_pkg::CH_DEL);
    assign has_room  = (r_fill < FILL_MAX);
    assign fill_zero = (r_fill == '0);
    assign idx_end   = ((r_rd_idx + 1'b1) == r_fill);
    assign rd_last   = ((r_cnt + 7'd1) == r_want) || idx_end;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign mem_we = i_cmd.accept && !is_read && !r_ready && !is_bs && has_room;
    assign mem_wd = is_eol ? cle_pkg::CH_LF : i_char_byte;

    always_comb begin
        ld      = 1'b0;
        ld_kind = cle_pkg::KIND_ECHO;
        ld_data = 8'd0;
        ld_last = 1'b1;
        priority if (i_cmd.accept) begin
            if (is_read) begin
                if (!r_ready) begin
                    ld      = 1'b1;
                    ld_kind = cle_pkg::KIND_NOTREADY;
                end
            end else if (r_ready) begin
                ld      = 1'b1;
                ld_kind = cle_pkg::KIND_REFUSED;
            end else if (is_eol) begin
                ld      = 1'b1;
                ld_data = cle_pkg::CH_LF;
            end else if (is_bs) begin
                ld      = !fill_zero;
                ld_data = cle_pkg::CH_BS;
                ld_last = 1'b0;
            end else begin
                ld      = printable;
                ld_data = i_char_byte;
            end
        end else if (i_cmd.echo_sp) begin
            ld      = 1'b1;
            ld_data = cle_pkg::CH_SPACE;
            ld_last = 1'b0;
        end else if (i_cmd.echo_bs2) begin
            ld      = 1'b1;
            ld_data = cle_pkg::CH_BS;
        end else if (i_cmd.rd_emit) begin
            ld      = 1'b1;
            ld_kind = cle_pkg::KIND_DATA;
            ld_data = r_mem_q;
            ld_last = rd_last;
        end else begin
            ld      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= mem_wd;
        end
        if (i_cmd.rd_fetch) begin
            r_mem_q <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && !is_read && !r_ready) begin
                if (is_eol) begin
                    if (has_room) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_ready  <= 1'b1;
                    r_rd_idx <= '0;
                end else if (is_bs) begin
                    if (!fill_zero) begin
                        r_fill <= r_fill - 1'b1;
                    end
                end else if (has_room) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.rd_emit) begin
                if (idx_end) begin
                    r_fill   <= '0;
                    r_rd_idx <= '0;
                    r_ready  <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.rd_go) begin
            r_want <= (i_read_count > BURST) ? BURST : i_read_count;
            r_cnt  <= 7'd0;
        end else if (i_cmd.rd_emit) begin
            r_cnt  <= r_cnt + 7'd1;
        end
        if (ld) begin
            r_kind <= ld_kind;
            r_data <= ld_data;
            r_last <= ld_last;
        end
    end

    always_comb begin
        o_status.out_free   = out_free;
        o_status.bs_go      = !is_read && !r_ready && is_bs && !fill_zero;
        o_status.rd_go      = is_read && r_ready && (i_read_count != 7'd0);
        o_status.rd_last    = rd_last;
        o_status.line_ready = r_ready;
        o_status.fill_zero  = fill_zero;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_last      = r_last;

endmodule

### sv/cle_ctrl.sv
// Controller of the canonical line editor: sequences echoes and read bursts.
// Depends on cle_pkg; commands cle_datapath through t_cmd.
`timescale 1ns / 1ps

module cle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cle_pkg::t_status  i_status,
    output cle_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO_SP,
        ST_ECHO_BS2,
        ST_RD_FETCH,
        ST_RD_EMIT
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
            end
            ST_ECHO_SP:  o_cmd.echo_sp  = i_status.out_free;
            ST_ECHO_BS2: o_cmd.echo_bs2 = i_status.out_free;
            ST_RD_FETCH: o_cmd.rd_fetch = 1'b1;
            ST_RD_EMIT:  o_cmd.rd_emit  = i_status.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.accept) begin
                        if (i_status.bs_go) begin
                            r_state <= ST_ECHO_SP;
                        end else if (i_status.rd_go) begin
                            r_state <= ST_RD_FETCH;
                        end
                    end
                end
                ST_ECHO_SP: begin
                    if (i_status.out_free) begin
                        r_state <= ST_ECHO_BS2;
                    end
                end
                ST_ECHO_BS2: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD_FETCH: r_state <= ST_RD_EMIT;
                ST_RD_EMIT: begin
                    if (i_status.out_free) begin
                        r_state <= i_status.rd_last ? ST_IDLE : ST_RD_FETCH;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/canonical_line_editor.sv
// Top level of the canonical line editor: joins cle_ctrl and cle_datapath.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
`timescale 1ns / 1ps

// Terminal-style line editor. Character items edit a line held in a single-port
// store of LINE_BYTES bytes (at most LINE_BYTES-1 stored) and give their echo;
// read items stream the finished line out. One result register sits on the
// output. A character item is handled in its accepting cycle; a backspace
// loads its first echo byte there and one more in each of ST_ECHO_SP and
// ST_ECHO_BS2; a read item has the accepting cycle, then for each byte a
// registered store read followed by a load of the result register. Output
// stalls hold each load step. No clearing pass follows reset.

module canonical_line_editor #(
    parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEF,
    parameter int READ_BURST = cle_pkg::READ_BURST_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_char_byte,
    input  logic [6:0] i_read_count,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic       o_last
);

    cle_pkg::t_cmd    cmd;
    cle_pkg::t_status status;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cle_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .READ_BURST (READ_BURST)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_operation  (i_operation),
        .i_char_byte  (i_char_byte),
        .i_read_count (i_read_count),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_last       (o_last)
    );

`ifndef NO_ASSERTIONS
    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!o_out_valid || !i_out_stall))
        else $error("item taken while result register blocked");

    a_ready_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.line_ready |-> !status.fill_zero)
        else $error("ready line is empty");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");
`endif

endmodule

### tb/tb_canonical_line_editor.sv
// Self-checking testbench for canonical_line_editor: directed edits and
// random line sequences, with a scoreboard class predicting echoes and read-back bytes.
// Depends on cle_pkg and canonical_line_editor.
`timescale 1ns / 1ps

module tb_canonical_line_editor;

    localparam int LINE_LEN    = cle_pkg::LINE_BYTES_DEF;
    localparam int BURST_MAX   = cle_pkg::READ_BURST_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        cle_pkg::t_kind kind;
        logic [7:0]     data;
        logic           last;
    } t_reply;

    class line_reply_board;
        t_reply      replies_due[$];
        t_reply      fresh[$];
        logic [7:0]  line_mem [LINE_LEN];
        int unsigned fill_len;
        int unsigned rd_pos;
        bit          line_done;
        int          faults;

        function new();
            fill_len  = 0;
            rd_pos    = 0;
            line_done = 1'b0;
            faults    = 0;
        endfunction

        function void emit(cle_pkg::t_kind k, logic [7:0] d);
            t_reply r;
            r.kind = k;
            r.data = d;
            r.last = 1'b0;
            fresh.push_back(r);
        endfunction

        function void store_byte(logic [7:0] b);
            if (fill_len < LINE_LEN - 1) begin
                line_mem[fill_len] = b;
                fill_len++;
            end
        endfunction

        // predicts the replies of one accepted item; returns how many
        function int take_item(logic op, logic [7:0] ch, logic [6:0] want);
            int unsigned n_want;
            n_want = want;
            fresh.delete();
            if (op == cle_pkg::OP_CHAR) begin
                if (line_done) begin
                    emit(cle_pkg::KIND_REFUSED, 8'd0);
                end else if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
                    store_byte(cle_pkg::CH_LF);
                    emit(cle_pkg::KIND_ECHO, cle_pkg::CH_LF);
                    line_done = 1'b1;
                    rd_pos    = 0;
                end else if (ch == cle_pkg::CH_BS || ch == cle_pkg::CH_DEL) begin
                    if (fill_len > 0) begin
                        fill_len--;
                        emit(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
                        emit(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE);
                        emit(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
                    end
                end else begin
                    store_byte(ch);
                    if (ch >= cle_pkg::CH_SPACE && ch < cle_pkg::CH_DEL)
                        emit(cle_pkg::KIND_ECHO, ch);
                end
            end else if (!line_done) begin
                emit(cle_pkg::KIND_NOTREADY, 8'd0);
            end else if (n_want != 0) begin
                if (n_want > BURST_MAX)
                    n_want = BURST_MAX;
                while (fresh.size() < n_want && rd_pos < fill_len) begin
                    emit(cle_pkg::KIND_DATA, line_mem[rd_pos]);
                    rd_pos++;
                end
                if (rd_pos >= fill_len) begin
                    fill_len  = 0;
                    rd_pos    = 0;
                    line_done = 1'b0;
                end
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                replies_due.push_back(fresh[i]);
            return fresh.size();
        endfunction

        function void match_reply(logic [1:0] kind, logic [7:0] data, logic last);
            t_reply exp;
            if (replies_due.size() == 0) begin
                faults++;
                $display("%0t: unexpected item, expected none, got kind %0d data %02h last %0b",
                         $time, kind, data, last);
                return;
            end
            exp = replies_due.pop_front();
            if (kind !== exp.kind) begin
                faults++;
                $display("%0t: kind expected %0d, got %0d", $time, exp.kind, kind);
            end
            if (data !== exp.data) begin
                faults++;
                $display("%0t: data expected %02h, got %02h", $time, exp.data, data);
            end
            if (last !== exp.last) begin
                faults++;
                $display("%0t: last expected %0b, got %0b", $time, exp.last, last);
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_operation;
    logic [7:0] i_char_byte;
    logic [6:0] i_read_count;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_kind;
    logic [7:0] o_data;
    logic       o_last;

    line_reply_board board;
    bit              calm;
    bit              hold_req;
    int              items_done;
    int              cycle_count = 0;

    canonical_line_editor u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_char_byte  (i_char_byte),
        .i_read_count (i_read_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.match_reply(o_kind, o_data, o_last);
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 15);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic op, input logic [7:0] ch, input logic [6:0] want);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_char_byte  <= ch;
        i_read_count <= want;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        void'(board.take_item(op, ch, want));
        items_done++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 62)
            return 8'($urandom_range(126, 32));
        if (roll < 74)
            return roll[0] ? cle_pkg::CH_BS : cle_pkg::CH_DEL;
        if (roll < 86)
            return 8'($urandom_range(31, 0));
        return 8'($urandom_range(255, 128));
    endfunction

    function automatic logic [6:0] read_want();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 7'($urandom_range(16, 1));
        if (roll < 90)
            return 7'($urandom_range(64, 17));
        if (roll < 95)
            return 7'd0;
        return 7'($urandom_range(127, 65));
    endfunction

    initial begin
        int  k;
        int  span;
        bit  pressed;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = cle_pkg::OP_CHAR;
        i_char_byte  = 8'd0;
        i_read_count = 7'd0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        pressed      = 1'b0;
        items_done   = 0;
        board        = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed edits
        send_item(cle_pkg::OP_READ, 8'h00, 7'd5);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_BS, 7'd0);
        send_item(cle_pkg::OP_CHAR, 8'h41, 7'd127);
        send_item(cle_pkg::OP_CHAR, 8'h00, 7'd1);
        send_item(cle_pkg::OP_CHAR, 8'hFF, 7'd64);
        send_item(cle_pkg::OP_CHAR, 8'h80, 7'd0);
        send_item(cle_pkg::OP_CHAR, 8'h7E, 7'd0);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_SPACE, 7'd0);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_DEL, 7'd0);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_BS, 7'd0);
        send_item(cle_pkg::OP_CHAR, 8'h1F, 7'd0);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_CR, 7'd0);
        send_item(cle_pkg::OP_CHAR, 8'h78, 7'd0);
        send_item(cle_pkg::OP_READ, 8'hFF, 7'd0);
        send_item(cle_pkg::OP_READ, 8'h00, 7'd1);
        send_item(cle_pkg::OP_READ, 8'h00, 7'd2);
        send_item(cle_pkg::OP_READ, 8'h00, 7'd127);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_LF, 7'd0);
        send_item(cle_pkg::OP_CHAR, cle_pkg::CH_CR, 7'd0);
        send_item(cle_pkg::OP_READ, 8'h00, 7'd64);
        send_item(cle_pkg::OP_READ, 8'h00, 7'd64);

        while (items_done < 200) begin
            calm = (items_done >= 90 && items_done < 140);
            if (!pressed && items_done >= 40) begin
                pressed  = 1'b1;
                hold_req = 1'b1;
                for (k = 0; k < 24; k++)
                    send_item(cle_pkg::OP_CHAR, 8'($urandom_range(126, 32)), 7'd0);
            end
            if ($urandom_range(9) == 0) begin
                for (k = 0; k < 3; k++)
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              7'($urandom_range(127)));
            end else begin
                if (!board.line_done && $urandom_range(7) == 0)
                    send_item(cle_pkg::OP_READ, 8'($urandom_range(255)), read_want());
                span = ($urandom_range(11) == 0) ? $urandom_range(60, 30) : $urandom_range(12);
                for (k = 0; k < span; k++)
                    send_item(cle_pkg::OP_CHAR, pick_char(), 7'($urandom_range(127)));
                // now and then the line is left open and runs into the next one
                if ($urandom_range(5) != 0) begin
                    send_item(cle_pkg::OP_CHAR,
                              $urandom_range(1) ? cle_pkg::CH_CR : cle_pkg::CH_LF,
                              7'($urandom_range(127)));
                    if ($urandom_range(4) == 0)
                        send_item(cle_pkg::OP_CHAR, pick_char(), 7'($urandom_range(127)));
                    while (board.line_done)
                        send_item(cle_pkg::OP_READ, 8'($urandom_range(255)), read_want());
                end
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (2 * BURST_MAX + 16) @(posedge i_clk);
        if (board.faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
